>>> sv/assert_macros.svh
// assertion helpers, clocked on clk and held off while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic clocked property check
`define ASSERT_PROP(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// implication check built on the generic form
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	`ASSERT_PROP(lbl, (ante) |-> (cons), msg)

`endif

>>> sv/hhr_pkg.sv
package hhr_pkg;

	// field widths
	localparam int HUE_W  = 15;
	localparam int Q_W    = 9;
	localparam int SEC_W  = 3;
	localparam int FRAC_W = 12;
	localparam int CN_W   = 17;
	localparam int MP_W   = 18;
	localparam int PROD_W = 28;
	localparam int NUM_W  = 29;

	// fixed point limits
	localparam logic [HUE_W-1:0]  HUE_MAX     = 15'd23039;
	localparam logic [FRAC_W-1:0] SECTOR_SPAN = 12'd3840;
	localparam logic [Q_W-1:0]    Q_ONE       = 9'd256;

	// what a channel shows: nothing, the x term or full chroma
	typedef enum logic [1:0] {
		SEL_ZERO,
		SEL_X,
		SEL_C
	} chan_sel_t;

	typedef struct packed {
		chan_sel_t r;
		chan_sel_t g;
		chan_sel_t b;
	} sel_set_t;

	// stage 1: clamped inputs, chroma and hue sector
	typedef struct packed {
		logic              act;
		logic [Q_W-1:0]    lv;
		logic [CN_W-1:0]   cn;
		logic [SEC_W-1:0]  sector;
		logic [FRAC_W-1:0] f;
		logic [7:0]        alpha;
	} front_t;

	// stage 2: scaled chroma, x product and offset
	typedef struct packed {
		logic [PROD_W-1:0] p;
		logic [PROD_W-1:0] cf;
		logic [NUM_W-1:0]  mc;
		logic [SEC_W-1:0]  sector;
		logic [7:0]        alpha;
	} mix_t;

	// channel roles for each 60 degree sector
	function automatic sel_set_t sector_sel(input logic [SEC_W-1:0] sector);
		sel_set_t s;
		unique case (sector)
			3'd0:    s = '{r: SEL_C,    g: SEL_X,    b: SEL_ZERO};
			3'd1:    s = '{r: SEL_X,    g: SEL_C,    b: SEL_ZERO};
			3'd2:    s = '{r: SEL_ZERO, g: SEL_C,    b: SEL_X};
			3'd3:    s = '{r: SEL_ZERO, g: SEL_X,    b: SEL_C};
			3'd4:    s = '{r: SEL_X,    g: SEL_ZERO, b: SEL_C};
			default: s = '{r: SEL_C,    g: SEL_ZERO, b: SEL_X};
		endcase
		return s;
	endfunction

endpackage

>>> sv/hhr_front.sv
module hhr_front
	import hhr_pkg::*;
(
	input  logic             clk,
	input  logic             en,
	input  logic             act,
	input  logic [HUE_W-1:0] hue,
	input  logic [Q_W-1:0]   saturation,
	input  logic [Q_W-1:0]   level,
	input  logic [7:0]       alpha_in,
	output front_t           stage_s1
);

	logic [HUE_W-1:0]  h_c;
	logic [Q_W-1:0]    s_c;
	logic [Q_W-1:0]    l_c;
	logic [Q_W:0]      l2;
	logic [Q_W-1:0]    l_dev;
	logic [Q_W-1:0]    mul_a;
	logic [2*Q_W-1:0]  cn_full;
	logic [SEC_W-1:0]  sec;
	logic [HUE_W-1:0]  base;
	logic [HUE_W-1:0]  frac_full;

	// clamp to the legal ranges
	assign h_c = (hue > HUE_MAX) ? HUE_MAX : hue;
	assign s_c = (saturation > Q_ONE) ? Q_ONE : saturation;
	assign l_c = (level > Q_ONE) ? Q_ONE : level;

	// chroma: (1 - |2l - 1|) * s for hsl, v * s for hsv
	assign l2    = {l_c, 1'b0};
	assign l_dev = (l2 >= {1'b0, Q_ONE}) ? Q_W'(l2 - {1'b0, Q_ONE})
	                                     : Q_W'({1'b0, Q_ONE} - l2);
	assign mul_a = act ? l_c : Q_ONE - l_dev;
	assign cn_full = mul_a * s_c;

	// hue sector and position inside it
	always_comb begin
		priority if (h_c >= HUE_W'(5 * SECTOR_SPAN)) begin
			sec  = 3'd5;
			base = HUE_W'(5 * SECTOR_SPAN);
		end else if (h_c >= HUE_W'(4 * SECTOR_SPAN)) begin
			sec  = 3'd4;
			base = HUE_W'(4 * SECTOR_SPAN);
		end else if (h_c >= HUE_W'(3 * SECTOR_SPAN)) begin
			sec  = 3'd3;
			base = HUE_W'(3 * SECTOR_SPAN);
		end else if (h_c >= HUE_W'(2 * SECTOR_SPAN)) begin
			sec  = 3'd2;
			base = HUE_W'(2 * SECTOR_SPAN);
		end else if (h_c >= HUE_W'(SECTOR_SPAN)) begin
			sec  = 3'd1;
			base = HUE_W'(SECTOR_SPAN);
		end else begin
			sec  = 3'd0;
			base = '0;
		end
	end
	assign frac_full = h_c - base;

	// stage 1 register
	always_ff @(posedge clk) begin
		if (en) begin
			stage_s1.act    <= act;
			stage_s1.lv     <= l_c;
			stage_s1.cn     <= cn_full[CN_W-1:0];
			stage_s1.sector <= sec;
			stage_s1.f      <= frac_full[FRAC_W-1:0];
			stage_s1.alpha  <= alpha_in;
		end
	end

endmodule

>>> sv/hhr_mix.sv
module hhr_mix
	import hhr_pkg::*;
(
	input  logic   clk,
	input  logic   en,
	input  front_t stage_s1,
	output mix_t   stage_s2
);

	logic [FRAC_W-1:0]      xf;
	logic [CN_W+FRAC_W-1:0] p_full;
	logic [CN_W+FRAC_W-1:0] cf_full;
	logic [MP_W-1:0]        lv_sh;
	logic [MP_W-1:0]        mp;
	logic [MP_W+FRAC_W-1:0] mc_full;

	// x weight falls on odd sectors
	assign xf = stage_s1.sector[0] ? SECTOR_SPAN - stage_s1.f : stage_s1.f;

	// chroma times x weight and times full span
	assign p_full  = stage_s1.cn * xf;
	assign cf_full = stage_s1.cn * SECTOR_SPAN;

	// offset term, in units of the x product
	assign lv_sh = {stage_s1.lv, 9'd0};
	assign mp    = stage_s1.act ? lv_sh - {stage_s1.cn, 1'b0}
	                            : lv_sh - {1'b0, stage_s1.cn};
	assign mc_full = mp * SECTOR_SPAN;

	// stage 2 register
	always_ff @(posedge clk) begin
		if (en) begin
			stage_s2.p      <= p_full[PROD_W-1:0];
			stage_s2.cf     <= cf_full[PROD_W-1:0];
			stage_s2.mc     <= mc_full[NUM_W-1:0];
			stage_s2.sector <= stage_s1.sector;
			stage_s2.alpha  <= stage_s1.alpha;
		end
	end

endmodule

>>> sv/hhr_chan.sv
module hhr_chan
	import hhr_pkg::*;
(
	input  logic              clk,
	input  logic              en3,
	input  logic              en4,
	input  chan_sel_t         sel,
	input  logic [PROD_W-1:0] p,
	input  logic [PROD_W-1:0] cf,
	input  logic [NUM_W-1:0]  mc,
	output logic [7:0]        chan_s4
);

	logic [PROD_W-1:0]  term;
	logic [NUM_W:0]     sum;
	logic [NUM_W-1:0]   num_s3;
	logic [NUM_W+4:0]   scaled;
	logic [8:0]         q;

	// pick this channel's share of the chroma
	always_comb begin
		unique case (sel)
			SEL_X:   term = p;
			SEL_C:   term = cf;
			default: term = '0;
		endcase
	end
	assign sum = {1'b0, term, 1'b0} + {1'b0, mc};

	// stage 3 register
	always_ff @(posedge clk) begin
		if (en3) begin
			num_s3 <= sum[NUM_W-1:0];
		end
	end

	// times 255 over the common denominator reduces to times 17 over 2^25
	assign scaled = {1'b0, num_s3, 4'd0} + {5'd0, num_s3};
	assign q      = scaled[NUM_W+4:NUM_W-4];

	// stage 4 register with saturation
	always_ff @(posedge clk) begin
		if (en4) begin
			chan_s4 <= q[8] ? 8'd255 : q[7:0];
		end
	end

endmodule

>>> sv/hsl_hsv_to_rgb.sv
// hsl or hsv to rgb, one pixel per request
// data passes the stage 1 to stage 4 registers from input accept to output valid
// throughput: one request per cycle when m_tready does not stall the four register stages
// each stage moves on when it is empty or the next stage moves
// reset clears the stage valid bits only, data registers are not reset
`include "assert_macros.svh"

module hsl_hsv_to_rgb
	import hhr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // hue[14:0], saturation[23:15], level[32:24], alpha_in[40:33]
	input  logic        s_tuser,  // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // red[7:0], green[15:8], blue[23:16], alpha_out[31:24]
);

	logic       v_s1, v_s2, v_s3, v_s4;
	logic       en1, en2, en3, en4;
	front_t     stage_s1;
	mix_t       stage_s2;
	sel_set_t   sel;
	logic [7:0] alpha_s3, alpha_s4;
	logic [7:0] red_s4, green_s4, blue_s4;

	// a stage advances when empty or when the next one advances
	assign en4 = !v_s4 || m_tready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign s_tready = en1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_tvalid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	hhr_front u_front (
		.clk        (clk),
		.en         (en1),
		.act        (s_tuser),
		.hue        (s_tdata[14:0]),
		.saturation (s_tdata[23:15]),
		.level      (s_tdata[32:24]),
		.alpha_in   (s_tdata[40:33]),
		.stage_s1   (stage_s1)
	);

	hhr_mix u_mix (
		.clk      (clk),
		.en       (en2),
		.stage_s1 (stage_s1),
		.stage_s2 (stage_s2)
	);

	// sector decides which channel gets chroma, x or nothing
	assign sel = sector_sel(stage_s2.sector);

	hhr_chan u_red (
		.clk     (clk),
		.en3     (en3),
		.en4     (en4),
		.sel     (sel.r),
		.p       (stage_s2.p),
		.cf      (stage_s2.cf),
		.mc      (stage_s2.mc),
		.chan_s4 (red_s4)
	);

	hhr_chan u_green (
		.clk     (clk),
		.en3     (en3),
		.en4     (en4),
		.sel     (sel.g),
		.p       (stage_s2.p),
		.cf      (stage_s2.cf),
		.mc      (stage_s2.mc),
		.chan_s4 (green_s4)
	);

	hhr_chan u_blue (
		.clk     (clk),
		.en3     (en3),
		.en4     (en4),
		.sel     (sel.b),
		.p       (stage_s2.p),
		.cf      (stage_s2.cf),
		.mc      (stage_s2.mc),
		.chan_s4 (blue_s4)
	);

	// alpha rides along with the channel stages
	always_ff @(posedge clk) begin
		if (en3) alpha_s3 <= stage_s2.alpha;
		if (en4) alpha_s4 <= alpha_s3;
	end

	assign m_tvalid = v_s4;
	assign m_tdata  = {alpha_s4, blue_s4, green_s4, red_s4};

	// a free output stage means the whole pipe can take a request
	`ASSERT_IMPL(a_ready_when_drained, !m_tvalid || m_tready, s_tready,
		"input not ready although output stage is free")

	// with the sink ready throughout, an accepted request reaches the output valid
	`ASSERT_PROP(a_latency,
		(s_tvalid && s_tready) ##1 m_tready ##1 m_tready ##1 m_tready |=> m_tvalid,
		"request did not reach the output in four cycles")

endmodule
